@@ hdl/pru_pkg.sv @@
// ----------------------------------------------------------------------------
// pru_pkg
// shared types and constants for the pixel replicate upscaler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pru_pkg;

    // colour triple, blue in the lowest byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef enum logic [0:0] {
        KIND_PIXEL = 1'b0,
        KIND_TICK  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_RUN    = 2'd0,
        ST_ROWEND = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    // register indexes on the configuration port
    localparam logic [0:0] REG_SCALE = 1'b0;
    localparam logic [0:0] REG_WIDTH = 1'b1;

    localparam int SCALE_W     = 7;
    localparam int SRC_WIDTH_W = 11;
    localparam int PAD_W       = 2;
    localparam int SCALE_MAX   = 100;

endpackage : pru_pkg

@@ hdl/pru_line_buffer.sv @@
// ----------------------------------------------------------------------------
// pru_line_buffer
// single-port-write, single-port-read line store with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pru_line_buffer #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  pru_pkg::pixel_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output pru_pkg::pixel_t rdata
);
    import pru_pkg::*;

    pixel_t mem [DEPTH];
    pixel_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : pru_line_buffer

@@ hdl/pixel_replicate_upscaler.sv @@
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler
// integer nearest-neighbour upscaler for 24-bit pixel rows
//
// latency: an accepted beat passes through the item stage and then the output
//   register, where its first result beat can be taken
// throughput: one item per cycle while the output is not stalled; an item
//   that closes a row gives two result beats and holds the input until its
//   second beat moves, as the single output register moves one beat per cycle
// reset: rst_n async, clears counters, handshake state and the registers
//   (scale 1, width 1); the line buffer is not cleared and needs no sweep
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_replicate_upscaler #(
    parameter int WIDTH_MAX = 1024
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [10:0] cfg_wdata,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
    input  logic [0:0]  s_tuser,   // kind[0]

    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_blue[7:0], out_green[15:8], out_red[23:16],
                                   // repeat_count[30:24], pad_bytes[32:31], zero above
    output logic [1:0]  m_tuser    // status[1:0]
);
    import pru_pkg::*;

    // address bits for a column, and bits that can hold the width itself
    localparam int AW = (WIDTH_MAX > 1) ? $clog2(WIDTH_MAX) : 1;
    localparam int WW = $clog2(WIDTH_MAX + 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SCALE_W-1:0]     scale_reg;
    logic [SRC_WIDTH_W-1:0] width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_W'(1);
            width_reg <= SRC_WIDTH_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SCALE: scale_reg <= cfg_wdata[SCALE_W-1:0];
                REG_WIDTH: width_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // effective values, clamped into range
    logic [SCALE_W-1:0] eff_scale;
    logic [WW-1:0]      eff_width;
    logic [PAD_W-1:0]   row_pad;

    always_comb
    begin
        if (scale_reg == '0)
            eff_scale = SCALE_W'(1);
        else if (32'(scale_reg) > SCALE_MAX)
            eff_scale = SCALE_W'(SCALE_MAX);
        else
            eff_scale = scale_reg;

        if (width_reg == '0)
            eff_width = WW'(1);
        else if (32'(width_reg) > WIDTH_MAX)
            eff_width = WW'(WIDTH_MAX);
        else
            eff_width = WW'(width_reg);
    end

    // row bytes are width*scale*3; since 3 is -1 mod 4 the padding is
    // simply width*scale mod 4
    assign row_pad = PAD_W'(PAD_W'(eff_width) * PAD_W'(eff_scale));

    // ------------------------------------------------------------------
    // row position and replay counter
    // ------------------------------------------------------------------
    logic [AW-1:0]      column_reg, column_next;
    logic [SCALE_W-1:0] replays_left_reg, replays_left_next;

    logic          in_accept;
    logic          is_pixel;
    logic          replay_active;
    logic          reject;
    logic [WW-1:0] col_inc;
    logic          row_end;
    logic          buf_we;
    logic          buf_re;

    assign in_accept     = s_tvalid && s_tready;
    assign is_pixel      = (kind_t'(s_tuser) == KIND_PIXEL);
    assign replay_active = (replays_left_reg != '0);

    // a pixel during replay or a tick outside replay is turned away
    assign reject  = is_pixel ? replay_active : !replay_active;
    assign col_inc = WW'(column_reg) + WW'(1);
    assign row_end = !reject && (col_inc >= eff_width);

    // writes happen only outside replay and reads only during it, so the
    // two never meet on one edge; a write is always settled before a later
    // read of the same column is issued
    assign buf_we = in_accept && is_pixel && !reject;
    assign buf_re = in_accept && !is_pixel && !reject;

    always_comb
    begin
        column_next       = column_reg;
        replays_left_next = replays_left_reg;
        if (in_accept && !reject)
        begin
            column_next = row_end ? '0 : AW'(col_inc);
            if (row_end)
            begin
                if (is_pixel)
                    replays_left_next = eff_scale - SCALE_W'(1);
                else
                    replays_left_next = replays_left_reg - SCALE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg       <= '0;
            replays_left_reg <= '0;
        end
        else
        begin
            column_reg       <= column_next;
            replays_left_reg <= replays_left_next;
        end
    end

    // ------------------------------------------------------------------
    // line buffer
    // ------------------------------------------------------------------
    pixel_t in_pixel;
    pixel_t buf_rdata;

    assign in_pixel = pixel_t'(s_tdata);

    pru_line_buffer #(
        .DEPTH (WIDTH_MAX),
        .AW    (AW)
    ) u_line_buffer (
        .clk   (clk),
        .we    (buf_we),
        .waddr (column_reg),
        .wdata (in_pixel),
        .re    (buf_re),
        .raddr (column_reg),
        .rdata (buf_rdata)
    );

    // ------------------------------------------------------------------
    // item stage: holds an accepted item while its one or two beats leave
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    logic               s1_first_reg;    // run or reject beat still to send
    status_t            s1_status_reg;
    logic               s1_from_buf_reg; // colour comes from the buffer read
    pixel_t             s1_pixel_reg;
    logic [SCALE_W-1:0] s1_rep_reg;
    logic               s1_rowend_reg;
    logic [PAD_W-1:0]   s1_pad_reg;

    logic    m_valid_reg;
    logic    beat_move;
    logic    beat_last;

    status_t            beat_status;
    pixel_t             beat_pixel;
    logic [SCALE_W-1:0] beat_rep;
    logic [PAD_W-1:0]   beat_pad;

    assign beat_move = s1_valid_reg && (!m_valid_reg || m_tready);
    assign beat_last = !s1_first_reg || !s1_rowend_reg;

    // next item enters as the current one hands over its last beat
    assign s_tready = !s1_valid_reg || (beat_move && beat_last);

    always_comb
    begin
        if (s1_first_reg)
        begin
            beat_status = s1_status_reg;
            beat_pad    = '0;
            if (s1_status_reg == ST_REJECT)
            begin
                beat_pixel = '0;
                beat_rep   = '0;
            end
            else
            begin
                beat_pixel = s1_from_buf_reg ? buf_rdata : s1_pixel_reg;
                beat_rep   = s1_rep_reg;
            end
        end
        else
        begin
            beat_status = ST_ROWEND;
            beat_pixel  = '0;
            beat_rep    = '0;
            beat_pad    = s1_pad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_first_reg <= 1'b1;
        end
        else if (beat_move)
        begin
            if (beat_last)
                s1_valid_reg <= 1'b0;
            else
                s1_first_reg <= 1'b0;
        end
    end

    // item payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_status_reg   <= reject ? ST_REJECT : ST_RUN;
            s1_from_buf_reg <= !is_pixel;
            s1_pixel_reg    <= in_pixel;
            s1_rep_reg      <= eff_scale;
            s1_rowend_reg   <= row_end;
            s1_pad_reg      <= row_pad;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    status_t            m_status_reg;
    pixel_t             m_pixel_reg;
    logic [SCALE_W-1:0] m_rep_reg;
    logic [PAD_W-1:0]   m_pad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (beat_move)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_move)
        begin
            m_status_reg <= beat_status;
            m_pixel_reg  <= beat_pixel;
            m_rep_reg    <= beat_rep;
            m_pad_reg    <= beat_pad;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'd0, m_pad_reg, m_rep_reg, m_pixel_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // an accepted beat always lands in the item stage
    a_item_captured: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg
    ) else $error("accepted item not held in item stage");

    // a reject beat carries no colour, count or padding
    a_reject_clean: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_REJECT) |-> (m_tdata == '0)
    ) else $error("reject beat with payload");

    // replay count stays below the largest scale
    a_replays_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        32'(replays_left_reg) < SCALE_MAX
    ) else $error("replay counter out of range");

    // column always addresses the line buffer
    a_column_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        32'(column_reg) < WIDTH_MAX
    ) else $error("column beyond line buffer");

endmodule : pixel_replicate_upscaler

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pixel replicate upscaler
//
// a queue of pending pixel and tick beats feeds a clocked driver, and a
// clocked monitor predicts the result beats of every accepted input beat
// with its own copy of the line buffer, column and replay count. result
// beats are checked field by field in order. a short directed part hits
// the register extremes, both rejects and a width change mid-row, then
// random phases of well-formed rows with some noise under mixed idling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import pru_pkg::*;

    localparam int LINE_DEPTH   = 1024;
    localparam int RANDOM_ITEMS = 1800;
    localparam int NOISE_PCT    = 8;
    localparam int WIDE_PHASE   = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    // one input beat as the bench sees it
    typedef struct packed {
        kind_t  kind;
        pixel_t px;
    } feed_item_t;

    // one result beat, fields as carried on the output stream
    typedef struct packed {
        status_t              status;
        pixel_t               px;
        logic [SCALE_W-1:0]   reps;
        logic [PAD_W-1:0]     pad;
    } upscale_beat_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_addr  = '0;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // blue[7:0], green[15:8], red[23:16]
    logic [0:0]  s_tuser   = '0;   // kind[0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // out_blue[7:0], out_green[15:8], out_red[23:16],
                                   // repeat_count[30:24], pad_bytes[32:31]
    logic [1:0]  m_tuser;          // status[1:0]

    // stimulus side
    feed_item_t    pixel_feed_q[$];
    feed_item_t    on_wire;
    bit            beat_open = 1'b0;
    int            gap_pct   = 0;
    int            stall_pct = 0;

    // predicted state of the block
    pixel_t              row_mem [LINE_DEPTH];
    int                  col          = 0;
    int                  replays_left = 0;
    int                  filled_depth = 0;   // entries below this have been written
    logic [SCALE_W-1:0]  scale_reg    = 7'd1;
    logic [10:0]         width_reg    = 11'd1;
    upscale_beat_t       upscaled_q[$];

    int error_count = 0;
    int cycle_count = 0;

    pixel_replicate_upscaler #(
        .WIDTH_MAX (LINE_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 clk = ~clk;

    // generous cycle limit, counts from the start of the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // out of range register values saturate
    function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
        if (v == 0)
            return 7'd1;
        if (v > SCALE_MAX)
            return 7'(SCALE_MAX);
        return v;
    endfunction

    function automatic logic [10:0] clamp_width(input logic [10:0] v);
        if (v == 0)
            return 11'd1;
        if (v > LINE_DEPTH)
            return 11'(LINE_DEPTH);
        return v;
    endfunction

    function automatic void push_result(input status_t st, input pixel_t px,
                                        input logic [SCALE_W-1:0] reps,
                                        input logic [PAD_W-1:0] pad);
        upscale_beat_t b;
        b.status = st;
        b.px     = px;
        b.reps   = reps;
        b.pad    = pad;
        upscaled_q.push_back(b);
    endfunction

    // expected result beats of one accepted input beat
    function automatic void upscale_item(input feed_item_t it);
        logic [SCALE_W-1:0] s;
        logic [10:0]        w;
        pixel_t             px;
        int                 row_bytes;
        s = clamp_scale(scale_reg);
        w = clamp_width(width_reg);
        // a pixel during a replay, or a tick with no replay pending, is refused
        if ((it.kind == KIND_PIXEL) != (replays_left == 0))
        begin
            push_result(ST_REJECT, '0, '0, '0);
            return;
        end
        if (it.kind == KIND_PIXEL)
        begin
            row_mem[col] = it.px;
            if (col + 1 > filled_depth)
                filled_depth = col + 1;
            px = it.px;
        end
        else
            px = row_mem[col];
        push_result(ST_RUN, px, s, '0);
        col++;
        // a shrunk width ends the row at once, even mid-row
        if (col >= int'(w))
        begin
            row_bytes = int'(w) * int'(s) * 3;
            col = 0;
            push_result(ST_ROWEND, '0, '0, PAD_W'((4 - row_bytes % 4) % 4));
            if (it.kind == KIND_PIXEL)
                replays_left = int'(s) - 1;
            else
                replays_left--;
        end
    endfunction

    function automatic void check_beat(input upscale_beat_t got);
        upscale_beat_t want;
        if (upscaled_q.size() == 0)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("unexpected result beat: st=%0d rgb=%06h rep=%0d pad=%0d",
                         got.status, got.px, got.reps, got.pad);
            return;
        end
        want = upscaled_q.pop_front();
        if (got.status !== want.status || got.px !== want.px ||
            got.reps !== want.reps || got.pad !== want.pad)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display({"result mismatch: expected st=%0d rgb=%06h rep=%0d pad=%0d,",
                          " got st=%0d rgb=%06h rep=%0d pad=%0d"},
                         want.status, want.px, want.reps, want.pad,
                         got.status, got.px, got.reps, got.pad);
        end
    endfunction

    // driver: inputs change on the falling edge, a beat is held until taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !($urandom_range(99) < stall_pct);
            if (!beat_open)
            begin
                if (pixel_feed_q.size() != 0 && !($urandom_range(99) < gap_pct))
                begin
                    on_wire   = pixel_feed_q.pop_front();
                    beat_open = 1'b1;
                    s_tvalid  <= 1'b1;
                    s_tdata   <= on_wire.px;
                    s_tuser   <= on_wire.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: predict on input beats, check on output beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                upscale_item(on_wire);
                beat_open = 1'b0;
            end
            if (m_tvalid && m_tready)
                check_beat({status_t'(m_tuser), pixel_t'(m_tdata[23:0]),
                            m_tdata[30:24], m_tdata[32:31]});
        end
    end

    task automatic push_feed(input kind_t k, input logic [23:0] rgb);
        feed_item_t it;
        it.kind = k;
        it.px   = rgb;
        pixel_feed_q.push_back(it);
    endtask

    // wait until every beat is sent and every result is back
    task automatic settle();
        while (pixel_feed_q.size() != 0 || beat_open || upscaled_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // register writes only while the block is idle
    task automatic write_reg(input logic [0:0] idx, input logic [10:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == REG_SCALE)
            scale_reg = val[SCALE_W-1:0];
        else
            width_reg = val;
    endtask

    task automatic close_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // well-formed rows and replays with random colours, sprinkled with
    // refused beats; a noisy phase picks the kind at random instead
    task automatic plan_phase(input int budget, input bit noisy, input bit finish_replay);
        int         g_col;
        int         g_rep;
        int         w;
        int         s;
        int         n;
        bit         live;
        feed_item_t it;
        g_col = col;
        g_rep = replays_left;
        w     = int'(clamp_width(width_reg));
        s     = int'(clamp_scale(scale_reg));
        n     = 0;
        while (n < budget || (finish_replay && g_rep != 0))
        begin
            it.px = 24'($urandom);
            if (n >= budget)
                live = 1'b1;
            else if (noisy)
                live = 1'($urandom_range(1));
            else
                live = $urandom_range(99) >= NOISE_PCT;
            if (live)
                it.kind = (g_rep == 0) ? KIND_PIXEL : KIND_TICK;
            else
                it.kind = (g_rep == 0) ? KIND_TICK : KIND_PIXEL;
            pixel_feed_q.push_back(it);
            if (live)
            begin
                g_col++;
                if (g_col >= w)
                begin
                    g_col = 0;
                    g_rep = (g_rep == 0) ? s - 1 : g_rep - 1;
                end
            end
            n++;
        end
    endtask

    initial
    begin
        int                 sent;
        int                 phase;
        int                 budget;
        int                 w_next;
        bit                 noisy;
        bit                 do_w;
        bit                 do_s;
        logic [10:0]        new_w;
        logic [SCALE_W-1:0] new_s;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, scale 1 and width 1: every pixel closes a row
        push_feed(KIND_PIXEL, 24'h000000);
        push_feed(KIND_PIXEL, 24'hFFFFFF);
        push_feed(KIND_TICK, 24'h000000);          // tick with no replay pending
        settle();

        // two-pixel rows replayed twice
        write_reg(REG_SCALE, 11'd3);
        write_reg(REG_WIDTH, 11'd2);
        close_writes();
        push_feed(KIND_PIXEL, 24'hFF00FF);
        push_feed(KIND_PIXEL, 24'h00FF00);
        push_feed(KIND_PIXEL, 24'h123456);         // pixel during a replay
        repeat (4) push_feed(KIND_TICK, 24'h000000);
        push_feed(KIND_TICK, 24'h000000);          // replay already done
        settle();

        // zero in both registers acts as one
        write_reg(REG_SCALE, 11'd0);
        write_reg(REG_WIDTH, 11'd0);
        close_writes();
        push_feed(KIND_PIXEL, 24'hA55AC3);
        push_feed(KIND_TICK, 24'h000000);
        settle();

        // scale above the maximum saturates
        write_reg(REG_SCALE, 11'd127);
        write_reg(REG_WIDTH, 11'd3);
        close_writes();
        push_feed(KIND_PIXEL, 24'h3C96E1);
        push_feed(KIND_PIXEL, 24'hC3691E);
        push_feed(KIND_PIXEL, 24'h0F0F0F);
        repeat (4) push_feed(KIND_TICK, 24'h000000);
        push_feed(KIND_PIXEL, 24'hF0F0F0);
        push_feed(KIND_TICK, 24'h000000);
        settle();

        // width shrunk in the middle of a replayed row ends it on the next tick
        write_reg(REG_WIDTH, 11'd1);
        close_writes();
        push_feed(KIND_TICK, 24'h000000);
        push_feed(KIND_TICK, 24'h000000);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 51; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 51; end
                default: begin gap_pct = 32; stall_pct = 32; end
            endcase
            if (phase == WIDE_PHASE)
            begin
                // finish any pending replay, then a long partial row at full width
                plan_phase(0, 1'b0, 1'b1);
                settle();
                write_reg(REG_WIDTH, 11'd2047);
                write_reg(REG_SCALE, 11'($urandom_range(1, 2)));
                close_writes();
                budget = 180;
                noisy  = 1'b0;
            end
            else
            begin
                do_w  = ($urandom_range(9) < 7) || (phase == WIDE_PHASE + 1);
                do_s  = $urandom_range(9) < 7;
                new_w = ($urandom_range(5) == 0) ? 11'($urandom_range(17, 64))
                                                 : 11'($urandom_range(1, 16));
                if ($urandom_range(19) == 0)
                    new_w = 11'd0;
                // never widen a replay past what the buffer has seen
                if (do_w && replays_left != 0 && int'(clamp_width(new_w)) > filled_depth)
                    do_w = 1'b0;
                w_next = do_w ? int'(clamp_width(new_w)) : int'(clamp_width(width_reg));
                if (w_next > 3 && clamp_scale(scale_reg) > 8)
                    do_s = 1'b1;
                if ($urandom_range(9) == 0 && w_next <= 3)
                    new_s = $urandom_range(1) ? 7'd0 : 7'($urandom_range(SCALE_MAX, 127));
                else
                    new_s = 7'($urandom_range(1, 8));
                if (do_w)
                    write_reg(REG_WIDTH, new_w);
                if (do_s)
                    write_reg(REG_SCALE, 11'(new_s));
                close_writes();
                noisy  = ($urandom_range(6) == 0);
                budget = noisy ? $urandom_range(20, 40) : $urandom_range(40, 120);
            end
            plan_phase(budget, noisy, 1'b0);
            sent += budget;
            phase++;
        end

        settle();
        repeat (20) @(negedge clk);
        error_count += upscaled_q.size();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule : tb
